/* sv/usb_ep0_pkg.sv */
package usb_ep0_pkg;

    localparam int NUM_DESC = 6;
    localparam logic [9:0] SETUP_ARM_COUNT = 10'd8;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_SETUP      = 4'd1,
        ST_DATA_IN    = 4'd2,
        ST_IN_IDLE    = 4'd3,
        ST_IN_ZERO    = 4'd4,
        ST_DATA_OUT   = 4'd5,
        ST_OUT_IDLE   = 4'd6,
        ST_STATUS_IN  = 4'd7,
        ST_STATUS_OUT = 4'd8
    } stage_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_ZLP   = 3'd2,
        ACT_STALL = 3'd3,
        ACT_ARM   = 3'd4,
        ACT_ADDR  = 3'd5,
        ACT_CFG   = 3'd6,
        ACT_DRAIN = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        OP_RESET    = 3'd0,
        OP_SETUP_RX = 3'd1,
        OP_SETUP_DN = 3'd2,
        OP_IN_CMPT  = 3'd3,
        OP_IN_EMPTY = 3'd4,
        OP_OUT_DATA = 3'd5,
        OP_OUT_CMPT = 3'd6,
        OP_OTHER_IN = 3'd7
    } opcode_t;

    localparam logic [1:0] DEV_DEFAULT    = 2'd0;
    localparam logic [1:0] DEV_ADDRESSED  = 2'd1;
    localparam logic [1:0] DEV_CONFIGURED = 2'd2;

    localparam logic [2:0] DESC_DEVICE = 3'd0;
    localparam logic [2:0] DESC_CONFIG = 3'd1;
    localparam logic [2:0] DESC_LANG   = 3'd2;
    localparam logic [2:0] DESC_REPORT = 3'd5;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] req_type;
        logic [7:0] req_code;
        logic [15:0] req_value;
        logic [15:0] req_length;
        logic [3:0] endpoint;
        logic [6:0] rx_length;
    } event_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] target_endpoint;
        logic [2:0] descriptor_select;
        logic [9:0] chunk_offset;
        logic [9:0] chunk_count;
        logic [6:0] device_address;
        logic [3:0] xfer_stage;
        logic [1:0] device_state;
        logic [7:0] configuration;
    } result_t;

    typedef struct packed {
        stage_t     stage;
        logic [1:0] usb_state;
        logic [9:0] remaining;
        logic [9:0] offset;
        logic [2:0] sel;
        logic       stall_pending;
        logic [7:0] active_cfg;
    } ctx_t;

endpackage

/* sv/usb_ep0_regs.sv */
module usb_ep0_regs
    import usb_ep0_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [NUM_DESC*10-1:0] desc_len
);
    logic [9:0] len_reg [NUM_DESC];
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg[0] <= 10'd18;
            len_reg[1] <= 10'd34;
            len_reg[2] <= 10'd4;
            len_reg[3] <= 10'd0;
            len_reg[4] <= 10'd0;
            len_reg[5] <= 10'd0;
        end
        else if (psel && penable && pwrite && (idx < 3'(NUM_DESC)))
        begin
            len_reg[idx] <= pwdata[9:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx < 3'(NUM_DESC))
        begin
            prdata = {22'd0, len_reg[idx]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_DESC; i++)
        begin
            desc_len[i*10 +: 10] = len_reg[i];
        end
    end
endmodule

/* sv/usb_ep0_core.sv */
module usb_ep0_core
    import usb_ep0_pkg::*;
#(
    parameter int EP0_PACKET = 64
)
(
    input  event_t                 ev,
    input  ctx_t                   ctx,
    input  logic [NUM_DESC*10-1:0] desc_len,
    output ctx_t                   ctx_nx,
    output result_t                res
);
    localparam logic [9:0] PKT = 10'(EP0_PACKET);

    always_comb
    begin
        logic [6:0]  rtype;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [9:0]  dlen;
        logic [2:0]  dsel;
        logic        start;
        logic        chunk;

        ctx_nx = ctx;
        res    = '0;
        rtype  = ev.req_type[6:0];
        hi     = ev.req_value[15:8];
        lo     = ev.req_value[7:0];
        start  = 1'b0;
        chunk  = 1'b0;
        dsel   = DESC_DEVICE;

        unique case (opcode_t'(ev.opcode))
            OP_RESET:
            begin
                ctx_nx.usb_state = DEV_DEFAULT;
                ctx_nx.stage     = ST_IDLE;
                ctx_nx.remaining = '0;
                ctx_nx.offset    = '0;
                res.action       = ACT_ADDR;
            end
            OP_SETUP_RX:
            begin
                ctx_nx.stage = ST_SETUP;
                if (rtype == 7'h00)
                begin
                    if (ev.req_code == 8'd1)
                    begin
                        ctx_nx.stage = ST_SETUP;
                    end
                    else if (ev.req_code == 8'd5)
                    begin
                        res.action         = ACT_ADDR;
                        res.device_address = lo[6:0];
                        ctx_nx.usb_state   = DEV_ADDRESSED;
                        ctx_nx.stage       = ST_STATUS_IN;
                    end
                    else if (ev.req_code == 8'd6)
                    begin
                        if (hi == 8'd1)
                        begin
                            start = 1'b1;
                            dsel  = DESC_DEVICE;
                        end
                        else if (hi == 8'd2)
                        begin
                            start = 1'b1;
                            dsel  = DESC_CONFIG;
                        end
                        else if (hi == 8'd3 && lo <= 8'd2)
                        begin
                            start = 1'b1;
                            dsel  = DESC_LANG + lo[2:0];
                        end
                        else
                        begin
                            ctx_nx.stall_pending = 1'b1;
                        end
                    end
                    else if (ev.req_code == 8'd9)
                    begin
                        ctx_nx.active_cfg   = lo;
                        res.action          = ACT_CFG;
                        res.target_endpoint = 4'd1;
                        ctx_nx.usb_state    = DEV_CONFIGURED;
                        ctx_nx.stage        = ST_STATUS_IN;
                    end
                    else
                    begin
                        ctx_nx.stall_pending = 1'b1;
                    end
                end
                else if (rtype == 7'h01)
                begin
                    if (hi == 8'h22)
                    begin
                        start = 1'b1;
                        dsel  = DESC_REPORT;
                    end
                    else
                    begin
                        ctx_nx.stall_pending = 1'b1;
                    end
                end
                else if (rtype == 7'h21)
                begin
                    if (ev.req_code == 8'h0A)
                    begin
                        res.action          = ACT_ZLP;
                        res.target_endpoint = 4'd1;
                        ctx_nx.stage        = ST_STATUS_IN;
                    end
                    else
                    begin
                        ctx_nx.stall_pending = 1'b1;
                    end
                end
                else
                begin
                    ctx_nx.stall_pending = 1'b1;
                end
            end
            OP_SETUP_DN:
            begin
                if (ctx.stall_pending)
                begin
                    res.action           = ACT_STALL;
                    res.target_endpoint  = ev.endpoint;
                    ctx_nx.stall_pending = 1'b0;
                end
                else if (ctx.stage == ST_STATUS_IN)
                begin
                    res.action = ACT_ZLP;
                end
                else if (ctx.stage == ST_DATA_IN)
                begin
                    chunk = 1'b1;
                end
            end
            OP_IN_CMPT:
            begin
                if (ev.endpoint == 4'd0)
                begin
                    if (ctx.stage == ST_IN_IDLE)
                    begin
                        chunk = 1'b1;
                    end
                    else if (ctx.stage == ST_IN_ZERO)
                    begin
                        res.action   = ACT_ZLP;
                        ctx_nx.stage = ST_STATUS_OUT;
                    end
                    else if (ctx.stage == ST_STATUS_OUT)
                    begin
                        res.action = ACT_ARM;
                    end
                end
            end
            OP_IN_EMPTY:
            begin
                if (ev.endpoint == 4'd0 && ctx.stage == ST_STATUS_IN)
                begin
                    ctx_nx.stage     = ST_IDLE;
                    ctx_nx.remaining = '0;
                    ctx_nx.offset    = '0;
                    res.action       = ACT_ARM;
                    res.chunk_count  = SETUP_ARM_COUNT;
                end
            end
            OP_OUT_DATA:
            begin
                if (ctx.stage == ST_STATUS_OUT)
                begin
                    res.action      = ACT_DRAIN;
                    res.chunk_count = {3'd0, ev.rx_length};
                    ctx_nx.stage    = ST_IDLE;
                end
                else if (ctx.stage == ST_IN_IDLE)
                begin
                    ctx_nx.stage = ST_IDLE;
                end
            end
            OP_OUT_CMPT:
            begin
                if (ctx.stage == ST_IDLE)
                begin
                    ctx_nx.remaining = '0;
                    ctx_nx.offset    = '0;
                    res.action       = ACT_ARM;
                    res.chunk_count  = SETUP_ARM_COUNT;
                end
                else if (ctx.stage == ST_OUT_IDLE)
                begin
                    ctx_nx.stage = ST_DATA_OUT;
                end
            end
            OP_OTHER_IN:
            begin
                ctx_nx.stage = ctx.stage;
            end
            default:
            begin
                ctx_nx.stage = ctx.stage;
            end
        endcase

        dlen = desc_len[dsel*10 +: 10];

        // Clamp the requested length to the descriptor size.
        if (start)
        begin
            ctx_nx.sel    = dsel;
            ctx_nx.offset = '0;
            ctx_nx.stage  = ST_DATA_IN;
            ctx_nx.remaining = (ev.req_length < {6'd0, dlen}) ? ev.req_length[9:0] : dlen;
        end

        // Emit one chunk of at most one packet.
        if (chunk)
        begin
            res.action            = ACT_WRITE;
            res.descriptor_select = ctx.sel;
            res.chunk_offset      = ctx.offset;
            if (ctx.remaining > PKT)
            begin
                res.chunk_count  = PKT;
                ctx_nx.offset    = ctx.offset + PKT;
                ctx_nx.remaining = ctx.remaining - PKT;
                ctx_nx.stage     = ST_IN_IDLE;
            end
            else
            begin
                res.chunk_count  = ctx.remaining;
                ctx_nx.stage     = (ctx.remaining == PKT) ? ST_IN_ZERO : ST_STATUS_OUT;
                ctx_nx.remaining = '0;
                ctx_nx.offset    = '0;
            end
        end

        res.xfer_stage    = ctx_nx.stage;
        res.device_state  = ctx_nx.usb_state;
        res.configuration = ctx_nx.active_cfg;
    end
endmodule

/* sv/usb_ep0_control_transfer_fsm_unit.sv */
// Channel  | Handshake         | Payload
// ---------+-------------------+---------------------------------------------
// event    | in_valid/in_stall | opcode, req_*, endpoint, rx_length
// result   | out_valid/out_stall | action ... configuration
// config   | APB               | six 10-bit descriptor lengths at 4*i
//
// Events are taken while in_stall is low; each result is registered when the
// output slot frees. The input register and the result register are parted
// by one level of decode logic, so the block keeps one word per cycle while
// out_stall is low. in_stall rises only while a result waits and the input
// register is also full. Reset returns the control stage to idle, the device
// to the default state, and the descriptor lengths to their reset values.
module usb_ep0_control_transfer_fsm_unit
    import usb_ep0_pkg::*;
#(
    parameter int EP0_PACKET = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  req_type,
    input  logic [7:0]  req_code,
    input  logic [15:0] req_value,
    input  logic [15:0] req_length,
    input  logic [3:0]  endpoint,
    input  logic [6:0]  rx_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [3:0]  target_endpoint,
    output logic [2:0]  descriptor_select,
    output logic [9:0]  chunk_offset,
    output logic [9:0]  chunk_count,
    output logic [6:0]  device_address,
    output logic [3:0]  xfer_stage,
    output logic [1:0]  device_state,
    output logic [7:0]  configuration,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [NUM_DESC*10-1:0] desc_len;
    event_t  ev_reg;
    logic    ev_valid_reg;
    ctx_t    ctx_reg;
    ctx_t    ctx_next;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    in_take;

    usb_ep0_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .desc_len (desc_len)
    );

    usb_ep0_core #(.EP0_PACKET(EP0_PACKET)) u_core (
        .ev       (ev_reg),
        .ctx      (ctx_reg),
        .desc_len (desc_len),
        .ctx_nx   (ctx_next),
        .res      (res_next)
    );

    // Move the staged event into the result register when that slot frees.
    assign advance  = ev_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = ev_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            ctx_reg       <= '{stage: ST_IDLE, usb_state: DEV_DEFAULT, default: '0};
        end
        else
        begin
            if (in_take)
            begin
                ev_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                ev_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_reg <= '{opcode, req_type, req_code, req_value, req_length,
                        endpoint, rx_length};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = res_valid_reg;
    assign action            = res_reg.action;
    assign target_endpoint   = res_reg.target_endpoint;
    assign descriptor_select = res_reg.descriptor_select;
    assign chunk_offset      = res_reg.chunk_offset;
    assign chunk_count       = res_reg.chunk_count;
    assign device_address    = res_reg.device_address;
    assign xfer_stage        = res_reg.xfer_stage;
    assign device_state      = res_reg.device_state;
    assign configuration     = res_reg.configuration;

    // Hold a stalled result steady.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_reg))
        else $error("result changed under stall");

    // Device state never takes the unused code.
    a_dev: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.usb_state != 2'd3)
        else $error("bad device state");

    // A bus reset clears the remaining byte count and the chunk offset.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ev_reg.opcode == OP_RESET
        |=> ctx_reg.remaining == '0 && ctx_reg.offset == '0)
        else $error("bus reset left bytes pending");

    // A stall action clears the pending flag.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.action == ACT_STALL |=> !ctx_reg.stall_pending)
        else $error("stall flag not cleared");
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import usb_ep0_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [7:0]  req_type;
    logic [7:0]  req_code;
    logic [15:0] req_value;
    logic [15:0] req_length;
    logic [3:0]  endpoint;
    logic [6:0]  rx_length;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  action;
    logic [3:0]  target_endpoint;
    logic [2:0]  descriptor_select;
    logic [9:0]  chunk_offset;
    logic [9:0]  chunk_count;
    logic [6:0]  device_address;
    logic [3:0]  xfer_stage;
    logic [1:0]  device_state;
    logic [7:0]  configuration;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    localparam int PKT = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    usb_ep0_control_transfer_fsm_unit dut (.*);

    // Testbench copy of the endpoint engine state and descriptor lengths.
    ctx_t       mdl;
    logic [9:0] mdl_len [NUM_DESC];

    event_t  pending_events [$];
    result_t expected_results [$];

    int errors;
    int events_sent;
    int results_seen;
    int idle_cycles;
    int rx_hold;       // long receiver hold-off, counted down by the monitor
    bit driver_pause;  // sender waits while set
    bit hold_done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Load one descriptor into the chunk engine.
    task automatic begin_descriptor(input logic [2:0] sel, input logic [15:0] wlen);
        logic [9:0] len;
        len = mdl_len[sel];
        mdl.sel = sel;
        mdl.remaining = (wlen < {6'd0, len}) ? wlen[9:0] : len;
        mdl.offset = '0;
        mdl.stage = ST_DATA_IN;
    endtask

    // Emit the next chunk, capped at the packet size.
    task automatic next_chunk(inout result_t r);
        r.action = ACT_WRITE;
        r.descriptor_select = mdl.sel;
        r.chunk_offset = mdl.offset;
        r.chunk_count = (mdl.remaining > PKT) ? 10'(PKT) : mdl.remaining;
        if (mdl.remaining > PKT)
        begin
            mdl.offset = mdl.offset + 10'(PKT);
            mdl.remaining = mdl.remaining - 10'(PKT);
            mdl.stage = ST_IN_IDLE;
        end
        else
        begin
            mdl.stage = (mdl.remaining == PKT) ? ST_IN_ZERO : ST_STATUS_OUT;
            mdl.remaining = '0;
            mdl.offset = '0;
        end
    endtask

    task automatic decode_request(input event_t e, inout result_t r);
        logic [6:0] rtype;
        logic [7:0] hi;
        logic [7:0] lo;
        rtype = e.req_type[6:0];
        hi = e.req_value[15:8];
        lo = e.req_value[7:0];
        mdl.stage = ST_SETUP;
        if (rtype == 7'h00)
        begin
            case (e.req_code)
                8'd1: ;  // clear feature: accepted, nothing changes
                8'd5:
                begin
                    r.action = ACT_ADDR;
                    r.device_address = lo[6:0];
                    mdl.usb_state = DEV_ADDRESSED;
                    mdl.stage = ST_STATUS_IN;
                end
                8'd6:
                begin
                    if (hi == 8'd1) begin_descriptor(DESC_DEVICE, e.req_length);
                    else if (hi == 8'd2) begin_descriptor(DESC_CONFIG, e.req_length);
                    else if (hi == 8'd3 && lo <= 8'd2)
                        begin_descriptor(DESC_LANG + lo[2:0], e.req_length);
                    else mdl.stall_pending = 1'b1;
                end
                8'd9:
                begin
                    mdl.active_cfg = lo;
                    r.action = ACT_CFG;
                    r.target_endpoint = 4'd1;
                    mdl.usb_state = DEV_CONFIGURED;
                    mdl.stage = ST_STATUS_IN;
                end
                default: mdl.stall_pending = 1'b1;
            endcase
        end
        else if (rtype == 7'h01)
        begin
            if (hi == 8'h22) begin_descriptor(DESC_REPORT, e.req_length);
            else mdl.stall_pending = 1'b1;
        end
        else if (rtype == 7'h21 && e.req_code == 8'h0A)
        begin
            r.action = ACT_ZLP;
            r.target_endpoint = 4'd1;
            mdl.stage = ST_STATUS_IN;
        end
        else
            mdl.stall_pending = 1'b1;
    endtask

    // Compute the action one event causes and advance the testbench state.
    task automatic predict_action(input event_t e, output result_t r);
        r = '0;
        case (opcode_t'(e.opcode))
            OP_RESET:
            begin
                mdl.usb_state = DEV_DEFAULT;
                mdl.stage = ST_IDLE;
                mdl.remaining = '0;
                mdl.offset = '0;
                r.action = ACT_ADDR;
            end
            OP_SETUP_RX: decode_request(e, r);
            OP_SETUP_DN:
            begin
                if (mdl.stall_pending)
                begin
                    r.action = ACT_STALL;
                    r.target_endpoint = e.endpoint;
                    mdl.stall_pending = 1'b0;
                end
                else if (mdl.stage == ST_STATUS_IN)
                    r.action = ACT_ZLP;
                else if (mdl.stage == ST_DATA_IN)
                    next_chunk(r);
            end
            OP_IN_CMPT:
            begin
                if (e.endpoint == 4'd0)
                begin
                    if (mdl.stage == ST_IN_IDLE)
                    begin
                        mdl.stage = ST_DATA_IN;
                        next_chunk(r);
                    end
                    else if (mdl.stage == ST_IN_ZERO)
                    begin
                        r.action = ACT_ZLP;
                        mdl.stage = ST_STATUS_OUT;
                    end
                    else if (mdl.stage == ST_STATUS_OUT)
                        r.action = ACT_ARM;
                end
            end
            OP_IN_EMPTY:
            begin
                if (e.endpoint == 4'd0 && mdl.stage == ST_STATUS_IN)
                begin
                    mdl.stage = ST_IDLE;
                    mdl.remaining = '0;
                    mdl.offset = '0;
                    r.action = ACT_ARM;
                    r.chunk_count = SETUP_ARM_COUNT;
                end
            end
            OP_OUT_DATA:
            begin
                if (mdl.stage == ST_STATUS_OUT)
                begin
                    r.action = ACT_DRAIN;
                    r.chunk_count = {3'd0, e.rx_length};
                    mdl.stage = ST_IDLE;
                end
                else if (mdl.stage == ST_IN_IDLE)
                    mdl.stage = ST_IDLE;
            end
            OP_OUT_CMPT:
            begin
                if (mdl.stage == ST_IDLE)
                begin
                    mdl.remaining = '0;
                    mdl.offset = '0;
                    r.action = ACT_ARM;
                    r.chunk_count = SETUP_ARM_COUNT;
                end
                else if (mdl.stage == ST_OUT_IDLE)
                    mdl.stage = ST_DATA_OUT;
            end
            default: ;
        endcase
        r.xfer_stage = mdl.stage;
        r.device_state = mdl.usb_state;
        r.configuration = mdl.active_cfg;
    endtask

    function automatic event_t make_event(input logic [2:0] op, input logic [7:0] rt,
                                          input logic [7:0] rc, input logic [15:0] rv,
                                          input logic [15:0] rl, input logic [3:0] ep,
                                          input logic [6:0] rx);
        event_t e;
        e.opcode = op;
        e.req_type = rt;
        e.req_code = rc;
        e.req_value = rv;
        e.req_length = rl;
        e.endpoint = ep;
        e.rx_length = rx;
        return e;
    endfunction

    function automatic event_t noise_event();
        return make_event(3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), 4'($urandom), 7'($urandom_range(0, 64)));
    endfunction

    function automatic logic [15:0] rand_wlen();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 200));
            2: return 16'(64 * $urandom_range(0, 4));
            default: return 16'hFFFF;
        endcase
    endfunction

    // Queue one control transfer with random content, which may be malformed.
    task automatic queue_transfer();
        int kind;
        logic [15:0] v;
        logic [7:0] rt;
        logic [7:0] rc;
        kind = $urandom_range(0, 9);
        rt = 8'h00;
        rc = 8'd6;
        v = 16'($urandom);
        case (kind)
            0: begin rc = 8'd5; end
            1: begin rc = 8'd9; end
            2: begin rt = 8'h21; rc = 8'h0A; end
            3: begin v = {8'd1, 8'($urandom)}; end
            4: begin v = {8'd2, 8'($urandom)}; end
            5: begin v = {8'd3, 8'($urandom_range(0, 3))}; end
            6: begin rt = 8'h01; v = {8'h22, 8'($urandom)}; end
            7: begin rc = 8'd1; end
            8: begin rt = {1'($urandom), 7'($urandom)}; rc = 8'($urandom); end
            default: begin rt = {1'($urandom), 7'h00}; rc = 8'($urandom_range(0, 12)); end
        endcase
        if ($urandom_range(0, 3) == 0) rt[7] = ~rt[7];
        pending_events.push_back(make_event(OP_SETUP_RX, rt, rc, v, rand_wlen(),
                                            4'd0, 7'd8));
        pending_events.push_back(make_event(OP_SETUP_DN, 8'($urandom), 8'($urandom),
                                            16'($urandom), 16'($urandom),
                                            4'($urandom), 7'($urandom_range(0, 64))));
        // Walk the IN chunks and the status stage.
        repeat ($urandom_range(1, 18))
        begin
            pending_events.push_back(make_event(OP_IN_CMPT, 8'($urandom), 8'($urandom),
                16'($urandom), 16'($urandom),
                ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd0, 7'($urandom)));
        end
        pending_events.push_back(make_event(OP_IN_EMPTY, 8'($urandom), 8'($urandom),
            16'($urandom), 16'($urandom), 4'd0, 7'($urandom_range(0, 64))));
        pending_events.push_back(make_event(OP_OUT_DATA, 8'($urandom), 8'($urandom),
            16'($urandom), 16'($urandom), 4'($urandom), 7'($urandom_range(0, 64))));
        pending_events.push_back(make_event(OP_OUT_CMPT, 8'($urandom), 8'($urandom),
            16'($urandom), 16'($urandom), 4'($urandom), 7'($urandom_range(0, 64))));
        if ($urandom_range(0, 5) == 0) pending_events.push_back(noise_event());
    endtask

    // Driver: offer the oldest pending word, with random gaps.
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                void'(pending_events.pop_front());
                events_sent++;
                if ($urandom_range(0, 9) < 3)
                    gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
            end
            if (!(in_valid && in_stall))
            begin
                if (gap > 0 || driver_pause || pending_events.size() == 0)
                begin
                    if (gap > 0) gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid   <= 1'b1;
                    opcode     <= pending_events[0].opcode;
                    req_type   <= pending_events[0].req_type;
                    req_code   <= pending_events[0].req_code;
                    req_value  <= pending_events[0].req_value;
                    req_length <= pending_events[0].req_length;
                    endpoint   <= pending_events[0].endpoint;
                    rx_length  <= pending_events[0].rx_length;
                end
            end
        end
    end

    // Predict at acceptance, sampled at the edge.
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            predict_action(make_event(opcode, req_type, req_code, req_value, req_length,
                                      endpoint, rx_length), r);
            expected_results.push_back(r);
        end
    end

    // Monitor: check each accepted result, stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected, action %0d", action);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (action !== want.action)
                    begin
                        $error("action: expected %0d, actual %0d", want.action, action);
                        errors++;
                    end
                    if (target_endpoint !== want.target_endpoint)
                    begin
                        $error("target_endpoint: expected %0d, actual %0d",
                               want.target_endpoint, target_endpoint);
                        errors++;
                    end
                    if (descriptor_select !== want.descriptor_select)
                    begin
                        $error("descriptor_select: expected %0d, actual %0d",
                               want.descriptor_select, descriptor_select);
                        errors++;
                    end
                    if (chunk_offset !== want.chunk_offset)
                    begin
                        $error("chunk_offset: expected %0d, actual %0d",
                               want.chunk_offset, chunk_offset);
                        errors++;
                    end
                    if (chunk_count !== want.chunk_count)
                    begin
                        $error("chunk_count: expected %0d, actual %0d",
                               want.chunk_count, chunk_count);
                        errors++;
                    end
                    if (device_address !== want.device_address)
                    begin
                        $error("device_address: expected %0d, actual %0d",
                               want.device_address, device_address);
                        errors++;
                    end
                    if (xfer_stage !== want.xfer_stage)
                    begin
                        $error("xfer_stage: expected %0d, actual %0d",
                               want.xfer_stage, xfer_stage);
                        errors++;
                    end
                    if (device_state !== want.device_state)
                    begin
                        $error("device_state: expected %0d, actual %0d",
                               want.device_state, device_state);
                        errors++;
                    end
                    if (configuration !== want.configuration)
                    begin
                        $error("configuration: expected %0d, actual %0d",
                               want.configuration, configuration);
                        errors++;
                    end
                end
            end
            // Hold off hard once mid-run so the block backs up into in_stall.
            if (!hold_done && events_sent > 400)
            begin
                hold_done = 1'b1;
                rx_hold = 60;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_stall <= 1'b1;
            end
            else if (events_sent % 300 < 60)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 19) == 0)
                out_stall <= 1'b1;
            else if (out_stall && $urandom_range(0, 3) != 0 && $urandom_range(0, 9) == 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 9) < 2);
        end
    end

    // Watchdog on cycles with no handshake.
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic apb_write(input int idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mdl_len[idx] = val[9:0];
    endtask

    // Send everything queued, hold the sender, and let the pipeline drain
    // before a register write.
    task automatic wait_idle();
        while (pending_events.size() != 0) @(posedge clk);
        driver_pause = 1'b1;
        while (expected_results.size() != 0 || in_valid) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_lengths(input int mode);
        for (int i = 0; i < NUM_DESC; i++)
        begin
            case (mode)
                0: apb_write(i, 32'd0);
                1: apb_write(i, 32'd1023);
                2: apb_write(i, 32'd64 * $urandom_range(0, 3));
                default: apb_write(i, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        req_type = '0;
        req_code = '0;
        req_value = '0;
        req_length = '0;
        endpoint = '0;
        rx_length = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        events_sent = 0;
        results_seen = 0;
        rx_hold = 0;
        hold_done = 1'b0;
        driver_pause = 1'b1;
        mdl = '0;
        mdl.stage = ST_IDLE;
        mdl_len[0] = 10'd18;
        mdl_len[1] = 10'd34;
        mdl_len[2] = 10'd4;
        mdl_len[3] = 10'd0;
        mdl_len[4] = 10'd0;
        mdl_len[5] = 10'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset-value lengths, every opcode and the named corner cases.
        pending_events.push_back(make_event(OP_RESET, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_SETUP_RX, 8'h00, 8'd5, 16'hFFFF, 16'h0, 4'd0, 7'd8));
        pending_events.push_back(make_event(OP_SETUP_DN, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_IN_EMPTY, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_SETUP_RX, 8'h00, 8'd6, 16'h0100, 16'hFFFF, 4'd0, 7'd8));
        pending_events.push_back(make_event(OP_SETUP_DN, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_IN_CMPT, 8'h00, 8'h00, 16'h0, 16'h0, 4'd5, 7'd0));
        pending_events.push_back(make_event(OP_IN_CMPT, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_OUT_DATA, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd64));
        pending_events.push_back(make_event(OP_SETUP_RX, 8'h00, 8'd6, 16'h0303, 16'h10, 4'd0, 7'd8));
        pending_events.push_back(make_event(OP_SETUP_DN, 8'h00, 8'h00, 16'h0, 16'h0, 4'd15, 7'd0));
        pending_events.push_back(make_event(OP_SETUP_RX, 8'hC2, 8'd1, 16'h0, 16'h0, 4'd0, 7'd8));
        pending_events.push_back(make_event(OP_SETUP_DN, 8'h00, 8'h00, 16'h0, 16'h0, 4'd9, 7'd0));
        pending_events.push_back(make_event(OP_SETUP_RX, 8'h00, 8'd1, 16'h0, 16'h0, 4'd0, 7'd8));
        pending_events.push_back(make_event(OP_SETUP_RX, 8'h01, 8'd6, 16'h2200, 16'h0, 4'd0, 7'd8));
        pending_events.push_back(make_event(OP_SETUP_DN, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_IN_CMPT, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_SETUP_RX, 8'h21, 8'h0A, 16'h0, 16'h0, 4'd0, 7'd8));
        pending_events.push_back(make_event(OP_SETUP_DN, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_IN_EMPTY, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_SETUP_RX, 8'h80, 8'd9, 16'h00FF, 16'h0, 4'd0, 7'd8));
        pending_events.push_back(make_event(OP_OUT_CMPT, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        pending_events.push_back(make_event(OP_OTHER_IN, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                            4'd15, 7'd127));
        pending_events.push_back(make_event(OP_OUT_CMPT, 8'h00, 8'h00, 16'h0, 16'h0, 4'd0, 7'd0));
        driver_pause = 1'b0;

        // Random phases under several length settings, extremes included.
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            write_lengths(phase < 2 ? phase : (phase == 2 ? 2 : 3));
            driver_pause = 1'b0;
            repeat (14) queue_transfer();
        end
        wait_idle();
        driver_pause = 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d events, checked %0d results over 7 descriptor length settings",
                 events_sent, results_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
